FILE: design/ilb_pkg.sv
// ilb_pkg: shared types and codes for the indexed list buffer
// holds command and status codes, word field widths and the cell control struct
// no dependencies
package ilb_pkg;

  // field widths of one input word and one result word
  localparam int CMD_W    = 3;
  localparam int IDX_W    = 8;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int IN_W     = ((CMD_W + IDX_W + VAL_W + 7) / 8) * 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic             wr_app;  // write the value at the append position
    logic             wr_idx;  // write the value at idx
    logic             up;      // cells above idx take the lower neighbor
    logic             dn;      // cells at and above idx take the upper neighbor
    logic [IDX_W-1:0] idx;
  } ilb_op_t;

endpackage

FILE: design/ilb_cell.sv
// ilb_cell: one storage cell of the list chain
// holds one entry and loads from the broadcast value or a neighbor
// depends on ilb_pkg
module ilb_cell #(
  parameter int POS = 0,
  parameter int CW  = 9
) (
  input  logic                                 clk,
  input  ilb_pkg::ilb_op_t                     op,
  input  logic [CW-1:0]                        app_pos,
  input  logic signed [ilb_pkg::VAL_W-1:0]     value,
  input  logic signed [ilb_pkg::VAL_W-1:0]     prev_q,
  input  logic signed [ilb_pkg::VAL_W-1:0]     next_q,
  output logic signed [ilb_pkg::VAL_W-1:0]     q
);
  import ilb_pkg::*;

  logic signed [VAL_W-1:0] q_r;
  logic signed [VAL_W-1:0] q_nxt;
  logic                    at_app;
  logic                    at_idx;
  logic                    above_idx;

  // position compares against the broadcast control
  assign at_app    = (int'(app_pos) == POS);
  assign at_idx    = (int'(op.idx) == POS);
  assign above_idx = (POS > int'(op.idx));

  // next entry: new value, shift up from below, or shift down from above
  always_comb begin
    q_nxt = q_r;
    if (op.wr_app && at_app) begin
      q_nxt = value;
    end else if (op.wr_idx && at_idx) begin
      q_nxt = value;
    end else if (op.up && above_idx) begin
      q_nxt = prev_q;
    end else if (op.dn && (above_idx || at_idx)) begin
      q_nxt = next_q;
    end
  end

  // entry storage, undefined until written
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

FILE: design/indexed_list_buffer.sv
// indexed_list_buffer: ordered list of signed 32-bit entries held in a chain of cells
// top level: command decode, count register, result register and cell chain
// depends on ilb_pkg and ilb_cell
//
// Usage: each input word carries a command (append, insert, set, get, remove),
// an index and a value; each command yields exactly one result word with a
// status, the old or read entry, and the entry count after the command.
// Input channel in_*: a word is taken on a rising edge with in_tvalid and
// in_tready high. Result channel out_*: same handshake.
// Path: a taken word is held in the command register, then its result is loaded
// into the result register, from which it is taken on the result channel.
// Throughput: one command per cycle while results are taken. The whole row of
// CAPACITY cells shifts together in the execute cycle for insert and remove;
// the read for set, get and remove selects one cell of the row.
// Stall: while a result waits unread, the next command is held in the command
// register and in_tready drops until the result is taken.
// Reset: rst_n (synchronous, active low) empties the list and both registers;
// entry contents are not cleared, and no entry above the count is ever read.
module indexed_list_buffer #(
  parameter  int CAPACITY = 256,
  localparam int CW       = $clog2(CAPACITY + 1),
  localparam int OUT_W    = ((ilb_pkg::STATUS_W + ilb_pkg::VAL_W + CW + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [ilb_pkg::IN_W-1:0]   in_tdata,   // cmd, index, value, zero pad
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [OUT_W-1:0]           out_tdata   // status, data_out, count_out, zero pad
);
  import ilb_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  // command register
  logic                    pend_r;
  logic                    pend_nxt;
  logic [CMD_W-1:0]        cmd_r;
  logic [IDX_W-1:0]        idx_r;
  logic signed [VAL_W-1:0] val_r;

  // list count and result register
  logic [CW-1:0]           n_r;
  logic [CW-1:0]           n_nxt;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_data_r;
  logic [OUT_W-1:0]        out_data_nxt;

  logic                    accept;
  logic                    exec;
  logic                    full;
  logic                    in_range;
  logic [STATUS_W-1:0]     status;
  logic signed [VAL_W-1:0] data;
  logic signed [VAL_W-1:0] rd_word;
  logic [AW-1:0]           rd_sel;
  ilb_op_t                 op_raw;
  ilb_op_t                 op;

  logic signed [VAL_W-1:0] cell_q [CAPACITY];

  // handshake: execute when the result register is free or being emptied
  assign exec      = pend_r && (!out_valid_r || out_tready);
  assign in_tready = !pend_r || exec;
  assign accept    = in_tvalid && in_tready;
  assign pend_nxt  = accept ? 1'b1 : (exec ? 1'b0 : pend_r);

  // range checks against the current count
  assign full     = (n_r == CW'(CAPACITY));
  assign in_range = (XW'(idx_r) < XW'(n_r));

  // read of the addressed cell, before this command changes it
  assign rd_sel  = AW'(idx_r);
  assign rd_word = cell_q[rd_sel];

  // command decode: status, returned word, new count and cell control
  always_comb begin
    status     = ST_OK;
    data       = '0;
    n_nxt      = n_r;
    op_raw     = '0;
    op_raw.idx = idx_r;
    case (cmd_r)
      CMD_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op_raw.wr_app = 1'b1;
          n_nxt         = n_r + CW'(1);
        end
      end
      CMD_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (!in_range) begin
          status = ST_RANGE;
        end else begin
          op_raw.wr_idx = 1'b1;
          op_raw.up     = 1'b1;
          n_nxt         = n_r + CW'(1);
        end
      end
      CMD_SET: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          data          = rd_word;
          op_raw.wr_idx = 1'b1;
        end
      end
      CMD_GET: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          data = rd_word;
        end
      end
      CMD_REMOVE: begin
        if (!in_range) begin
          status = ST_RANGE;
        end else begin
          data      = rd_word;
          op_raw.dn = 1'b1;
          n_nxt     = n_r - CW'(1);
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  // cells change only in the execute cycle
  always_comb begin
    op     = '0;
    op.idx = idx_r;
    if (exec) begin
      op = op_raw;
    end
  end

  assign out_data_nxt = OUT_W'({n_nxt, data, status});

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (exec) begin
        n_r         <= n_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_tdata[CMD_W-1:0];
      idx_r <= in_tdata[CMD_W +: IDX_W];
      val_r <= in_tdata[CMD_W + IDX_W +: VAL_W];
    end
    if (exec) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // chain of cells, each wired to its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] prev_q;
    logic signed [VAL_W-1:0] next_q;
    if (i == 0) begin : g_first
      assign prev_q = '0;
    end else begin : g_prev
      assign prev_q = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_q = '0;
    end else begin : g_next
      assign next_q = cell_q[i+1];
    end
    ilb_cell #(
      .POS (i),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .app_pos (n_r),
      .value   (val_r),
      .prev_q  (prev_q),
      .next_q  (next_q),
      .q       (cell_q[i])
    );
  end

`ifndef NO_ASSERTIONS
  // count never passes the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // full status only reported for a full list
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    exec && (status == ST_FULL) |-> full)
    else $error("full status with room left");

  // count moves by at most one per command
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> (n_r == $past(n_nxt)) &&
             ((n_r == $past(n_r)) || (n_r == $past(n_r) + CW'(1)) ||
              (n_r == $past(n_r) - CW'(1))))
    else $error("count step wrong");

  // count holds when no command executes
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !exec |=> $stable(n_r))
    else $error("count changed without a command");
`endif

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for indexed_list_buffer, runs directed rows then three random phases
// a shadow copy of the list predicts each result not given in its row; depends on ilb_pkg and indexed_list_buffer
module tb;
  import ilb_pkg::*;

  localparam int CAP        = 256;
  localparam int CNT_W      = 9;
  localparam int OUT_W      = ((STATUS_W + VAL_W + CNT_W + 7) / 8) * 8;
  localparam int N_OPS      = 6;   // five commands plus the undefined codes
  localparam int REPORT_MAX = 10;
  localparam int HOLD_LEN   = 300;

  // undefined command codes, all answered with a range status
  localparam logic [CMD_W-1:0] CMD_BAD_LO = CMD_REMOVE + 3'd1;
  localparam logic [CMD_W-1:0] CMD_BAD_HI = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    data;
    logic [CNT_W-1:0]    count;
  } list_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [IDX_W-1:0]    idx;
    logic [VAL_W-1:0]    val;
    logic                typed;    // expected result given in the row itself
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    data;
    logic [CNT_W-1:0]    count;
  } list_row_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;  // cmd, index, value, zero pad
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;        // status, data_out, count_out, zero pad

  int send_idle_pct = 15;
  int recv_idle_pct = 54;
  int hold_left     = 0;
  int mismatches    = 0;
  bit hold_req      = 1'b0;
  bit hold_taken    = 1'b0;

  // shadow of the list contents and the expected result words in order
  logic [VAL_W-1:0] shadow_words [CAP];
  int unsigned      shadow_count = 0;
  list_result_t     pending_results [$];

  // op weights per phase: append, insert, set, get, remove, undefined
  int op_weight [3][N_OPS] = '{
    '{70, 18,  4,  4,  2, 2},   // fill until full, then hit the full status
    '{18, 10, 14, 15, 40, 3},   // mixed, slowly draining
    '{ 5,  3,  7,  7, 75, 3}    // drain down to empty
  };

  // directed rows, starting from an empty list
  list_row_t directed_rows [25] = '{
    '{CMD_GET,    8'd0,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000, 9'd0},
    '{CMD_REMOVE, 8'd0,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000, 9'd0},
    '{CMD_INSERT, 8'd0,   32'h1111_1111, 1'b1, ST_RANGE, 32'h0000_0000, 9'd0},
    '{CMD_SET,    8'd0,   32'h2222_2222, 1'b1, ST_RANGE, 32'h0000_0000, 9'd0},
    '{CMD_APPEND, 8'd0,   32'h7fff_ffff, 1'b1, ST_OK,    32'h0000_0000, 9'd1},
    '{CMD_APPEND, 8'd255, 32'h8000_0000, 1'b1, ST_OK,    32'h0000_0000, 9'd2},
    '{CMD_APPEND, 8'd0,   32'h0000_0000, 1'b1, ST_OK,    32'h0000_0000, 9'd3},
    '{CMD_APPEND, 8'd0,   32'hffff_ffff, 1'b1, ST_OK,    32'h0000_0000, 9'd4},
    '{CMD_GET,    8'd0,   32'h0000_0000, 1'b1, ST_OK,    32'h7fff_ffff, 9'd4},
    '{CMD_GET,    8'd255, 32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000, 9'd4},
    '{CMD_INSERT, 8'd4,   32'h3333_3333, 1'b1, ST_RANGE, 32'h0000_0000, 9'd4},
    '{CMD_INSERT, 8'd0,   32'h1234_5678, 1'b1, ST_OK,    32'h0000_0000, 9'd5},
    '{CMD_GET,    8'd1,   32'h0000_0000, 1'b1, ST_OK,    32'h7fff_ffff, 9'd5},
    '{CMD_SET,    8'd4,   32'ha5a5_a5a5, 1'b1, ST_OK,    32'hffff_ffff, 9'd5},
    '{CMD_SET,    8'd5,   32'h4444_4444, 1'b1, ST_RANGE, 32'h0000_0000, 9'd5},
    '{CMD_REMOVE, 8'd0,   32'h0000_0000, 1'b1, ST_OK,    32'h1234_5678, 9'd4},
    '{CMD_REMOVE, 8'd3,   32'h0000_0000, 1'b1, ST_OK,    32'ha5a5_a5a5, 9'd3},
    '{CMD_REMOVE, 8'd3,   32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000, 9'd3},
    '{CMD_BAD_LO, 8'd0,   32'h5555_5555, 1'b1, ST_RANGE, 32'h0000_0000, 9'd3},
    '{CMD_BAD_LO + 3'd1, 8'd0, 32'h0000_0000, 1'b1, ST_RANGE, 32'h0000_0000, 9'd3},
    '{CMD_BAD_HI, 8'd255, 32'hffff_ffff, 1'b1, ST_RANGE, 32'h0000_0000, 9'd3},
    '{CMD_INSERT, 8'd2,   32'h5a5a_5a5a, 1'b0, ST_OK,    32'h0000_0000, 9'd0},
    '{CMD_GET,    8'd2,   32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000, 9'd0},
    '{CMD_REMOVE, 8'd1,   32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000, 9'd0},
    '{CMD_GET,    8'd1,   32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000, 9'd0}
  };

  indexed_list_buffer #(.CAPACITY(CAP)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one command to the shadow list and work out its result word
  function automatic list_result_t list_apply(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                              logic [VAL_W-1:0] val);
    list_result_t r;
    int unsigned  n;
    bit           in_range;
    int           i;
    n        = shadow_count;
    in_range = idx < n;
    r.status = ST_OK;
    r.data   = '0;
    case (cmd)
      CMD_APPEND: begin
        if (n >= CAP) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[n] = val;
          shadow_count    = n + 1;
        end
      end
      CMD_INSERT: begin
        // full check wins over the position check
        if (n >= CAP) begin
          r.status = ST_FULL;
        end else if (!in_range) begin
          r.status = ST_RANGE;
        end else begin
          for (i = n; i > idx; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[idx] = val;
          shadow_count      = n + 1;
        end
      end
      CMD_SET: begin
        if (!in_range) begin
          r.status = ST_RANGE;
        end else begin
          r.data            = shadow_words[idx];
          shadow_words[idx] = val;
        end
      end
      CMD_GET: begin
        if (!in_range) r.status = ST_RANGE;
        else r.data = shadow_words[idx];
      end
      CMD_REMOVE: begin
        if (!in_range) begin
          r.status = ST_RANGE;
        end else begin
          r.data = shadow_words[idx];
          for (i = idx; i < n - 1; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count = n - 1;
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.count = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  // offer one command word, starting and ending at a falling edge
  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                          logic [VAL_W-1:0] val, logic typed, list_result_t given);
    list_result_t model_res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - CMD_W - IDX_W - VAL_W){1'b0}}, val, idx, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model_res = list_apply(cmd, idx, val);
    pending_results.push_back(typed ? given : model_res);
    @(negedge clk);
  endtask

  // random commands with an op mix chosen by phase; indexes mostly in range
  task automatic run_phase(int phase, int n_items);
    int               total;
    int               pick;
    int               op;
    int               k;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    total = 0;
    for (k = 0; k < N_OPS; k++) total += op_weight[phase][k];
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(total - 1);
      op   = 0;
      while (pick >= op_weight[phase][op]) begin
        pick -= op_weight[phase][op];
        op++;
      end
      case (op)
        0:       cmd = CMD_APPEND;
        1:       cmd = CMD_INSERT;
        2:       cmd = CMD_SET;
        3:       cmd = CMD_GET;
        4:       cmd = CMD_REMOVE;
        default: cmd = CMD_BAD_LO + 3'($urandom_range(CMD_BAD_HI - CMD_BAD_LO));
      endcase
      pick = $urandom_range(99);
      if (pick < 80 && shadow_count > 0) idx = IDX_W'($urandom_range(shadow_count - 1));
      else if (pick < 88) idx = (shadow_count >= CAP) ? 8'd255 : shadow_count[IDX_W-1:0];
      else idx = IDX_W'($urandom_range(255));
      case ($urandom_range(19))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7fff_ffff;
        2:       val = '0;
        3:       val = '1;
        default: val = $urandom;
      endcase
      send_cmd(cmd, idx, val, 1'b0, '0);
    end
  endtask

  task automatic note_mismatch(string what, list_result_t want, list_result_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t %s: want status %0d data %h count %0d, got status %0d data %h count %0d",
               $realtime, what, want.status, want.data, want.count,
               got.status, got.data, got.count);
  endtask

  // result side: random ready, or a long hold-off counted down here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_taken) begin
      out_tready <= 1'b0;
      hold_left  = HOLD_LEN - 1;
      hold_taken = 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each taken result word with the oldest expected one
  always @(posedge clk) begin : check_result
    list_result_t got;
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tdata[STATUS_W-1:0];
      got.data   = out_tdata[STATUS_W +: VAL_W];
      got.count  = out_tdata[STATUS_W + VAL_W +: CNT_W];
      if (pending_results.size() == 0) begin
        note_mismatch("result with none pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status || got.data != want.data || got.count != want.count)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  // main sequence
  initial begin : stimulus
    list_result_t given;
    int           r;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < 25; r++) begin
      given.status = directed_rows[r].status;
      given.data   = directed_rows[r].data;
      given.count  = directed_rows[r].count;
      send_cmd(directed_rows[r].cmd, directed_rows[r].idx, directed_rows[r].val,
               directed_rows[r].typed, given);
    end
    run_phase(0, 360);

    // swap idling; hold the result side long enough to back up the input
    send_idle_pct = 54;
    recv_idle_pct = 15;
    hold_req      = 1'b1;
    run_phase(1, 300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(2, 370);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("indexed_list_buffer test passed");
    end else begin
      $display("indexed_list_buffer test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("indexed_list_buffer test failed");
    $finish;
  end

endmodule

FILE: sim.f
design/ilb_pkg.sv
design/ilb_cell.sv
design/indexed_list_buffer.sv
bench/tb.sv
